// ----- src/cws_pkg.sv -----
package cws_pkg;

    typedef enum logic [2:0] {
        PH_STOP     = 3'd0,
        PH_BEGIN    = 3'd1,
        PH_SPINDLE  = 3'd2,
        PH_TRAVERSE = 3'd3,
        PH_REVERSE  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_MANUAL = 3'd1,
        ACT_SLOWER = 3'd2,
        ACT_FASTER = 3'd3,
        ACT_MENU   = 3'd4,
        ACT_START  = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        CFG_TURN_TARGET = 2'd0,
        CFG_SPINDLE_CW  = 2'd1,
        CFG_LAYER_STEPS = 2'd2,
        CFG_PITCH_STEPS = 2'd3
    } t_cfg_index;

    localparam logic [7:0] TRAVERSE_PACE = 8'd30;
    localparam logic [3:0] SPEED_MIN     = 4'd1;
    localparam logic [3:0] SPEED_MAX     = 4'd10;

    typedef struct packed {
        logic [15:0] turn_target;
        logic        spindle_cw;
        logic [15:0] layer_steps;
        logic [9:0]  pitch_steps;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] turns;
        logic        trav_dir;
        logic        rot_seen;
        logic [7:0]  sp_timer;
        logic [7:0]  tr_timer;
        logic [15:0] layer_pos;
        logic [15:0] pitch_mark;
        logic        manual;
        logic [3:0]  speed;
        logic        motor_en;
    } t_state;

    // field order matches the tdata layout, lowest bit last in the list
    typedef struct packed {
        logic [3:0]  speed_level;
        logic        manual_mode;
        logic        menu_request;
        logic        finished;
        logic [15:0] turn_count;
        logic        motor_on;
        logic        traverse_direction;
        logic        traverse_step;
        logic        spindle_step;
    } t_result;

    // spindle step interval in ticks per speed level; out-of-range levels clamp
    function automatic logic [7:0] pace(input logic [3:0] speed);
        logic [7:0] p;
        case (speed) inside
            4'd0, 4'd1: p = 8'd230;
            4'd2:       p = 8'd130;
            4'd3:       p = 8'd70;
            4'd4:       p = 8'd30;
            4'd5:       p = 8'd20;
            4'd6:       p = 8'd18;
            4'd7:       p = 8'd16;
            4'd8:       p = 8'd12;
            4'd9:       p = 8'd11;
            default:    p = 8'd10;
        endcase
        return p;
    endfunction

endpackage

// ----- src/cws_step.sv -----
module cws_step (
    input  cws_pkg::t_state  i_state,
    input  cws_pkg::t_cfg    i_cfg,
    input  logic [2:0]       i_action,
    input  logic             i_rotation,
    output cws_pkg::t_state  o_state,
    output cws_pkg::t_result o_result
);

    cws_pkg::t_state  n;
    cws_pkg::t_action act;
    logic             spin;
    logic             trav;
    logic             done;
    logic             menu;
    logic [15:0]      since_mark;

    assign act = cws_pkg::t_action'(i_action);

    always_comb begin
        n          = i_state;
        spin       = 1'b0;
        trav       = 1'b0;
        done       = 1'b0;
        menu       = 1'b0;
        since_mark = 16'd0;

        if (i_rotation) n.rot_seen = 1'b1;
        if (n.sp_timer != 8'hFF) n.sp_timer = n.sp_timer + 8'd1;
        if (n.tr_timer != 8'hFF) n.tr_timer = n.tr_timer + 8'd1;

        if (act == cws_pkg::ACT_START) begin
            n.speed  = cws_pkg::SPEED_MIN;
            n.manual = 1'b1;
            n.phase  = cws_pkg::PH_BEGIN;
        end else begin
            unique case (i_state.phase)
                cws_pkg::PH_BEGIN: begin
                    n.sp_timer   = 8'd0;
                    n.tr_timer   = 8'd0;
                    n.trav_dir   = 1'b1;
                    n.turns      = 16'd0;
                    n.rot_seen   = 1'b0;
                    n.layer_pos  = 16'd0;
                    n.pitch_mark = 16'd0;
                    n.phase      = cws_pkg::PH_SPINDLE;
                end
                cws_pkg::PH_SPINDLE, cws_pkg::PH_TRAVERSE: begin
                    // spindle part: a pending rotation counts one turn
                    if (n.rot_seen) begin
                        n.rot_seen = 1'b0;
                        n.phase    = cws_pkg::PH_TRAVERSE;
                        if (n.turns != 16'hFFFF) n.turns = n.turns + 16'd1;
                    end else if (!n.manual && n.sp_timer >= cws_pkg::pace(n.speed)) begin
                        spin       = 1'b1;
                        n.sp_timer = 8'd0;
                    end
                    // traverse part runs only when the tick began in traverse
                    if (i_state.phase == cws_pkg::PH_TRAVERSE) begin
                        since_mark = n.layer_pos - n.pitch_mark;
                        if (n.layer_pos >= i_cfg.layer_steps) begin
                            n.phase      = cws_pkg::PH_REVERSE;
                            n.layer_pos  = 16'd0;
                            n.pitch_mark = 16'd0;
                        end else if ({6'd0, i_cfg.pitch_steps} <= since_mark) begin
                            n.pitch_mark = n.layer_pos;
                            n.phase      = cws_pkg::PH_SPINDLE;
                            if (n.manual) n.motor_en = 1'b0;
                        end else begin
                            if (n.manual) n.motor_en = 1'b1;
                            if (n.tr_timer >= cws_pkg::TRAVERSE_PACE) begin
                                trav        = 1'b1;
                                n.layer_pos = n.layer_pos + 16'd1;
                                n.tr_timer  = 8'd0;
                            end
                        end
                    end
                end
                cws_pkg::PH_REVERSE: begin
                    n.trav_dir = ~n.trav_dir;
                    n.phase    = cws_pkg::PH_SPINDLE;
                end
                default: ;
            endcase

            if (i_cfg.turn_target <= n.turns) begin
                n.phase      = cws_pkg::PH_STOP;
                n.layer_pos  = 16'd0;
                n.pitch_mark = 16'd0;
                n.motor_en   = 1'b0;
                done         = 1'b1;
            end else begin
                unique case (act)
                    cws_pkg::ACT_MANUAL: begin
                        n.manual   = ~n.manual;
                        n.motor_en = ~n.manual;
                    end
                    cws_pkg::ACT_SLOWER: begin
                        if (n.speed > cws_pkg::SPEED_MIN) n.speed = n.speed - 4'd1;
                    end
                    cws_pkg::ACT_FASTER: begin
                        if (n.speed < cws_pkg::SPEED_MAX) n.speed = n.speed + 4'd1;
                    end
                    cws_pkg::ACT_MENU: menu = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign o_state = n;

    always_comb begin
        o_result.spindle_step       = spin;
        o_result.traverse_step      = trav;
        o_result.traverse_direction = n.trav_dir;
        o_result.motor_on           = n.motor_en;
        o_result.turn_count         = n.turns;
        o_result.finished           = done;
        o_result.menu_request       = menu;
        o_result.manual_mode        = n.manual;
        o_result.speed_level        = n.speed;
    end

endmodule

// ----- src/coil_winding_sequencer.sv -----
// Coil winder sequencer. Each request on the slave stream is one microsecond
// tick carrying a key action and the rotation sensor bit; each tick yields
// exactly one result on the master stream with the stepper pulses, motor
// enable, turn count and status. One tick is taken every clock cycle: the
// whole state update is a single pass of logic from the state registers into
// the result register, and only master back-pressure slows the flow.
// Configuration writes are taken at any time, one per cycle,
// and should only be issued while no tick is in flight.
module coil_winding_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream: [2:0] action, [3] rotation_pulse, [7:4] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // master stream: [0] spindle_step, [1] traverse_step, [2] traverse_direction,
    // [3] motor_on, [19:4] turn_count, [20] finished, [21] menu_request,
    // [22] manual_mode, [26:23] speed_level, [31:27] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    cws_pkg::t_cfg    r_cfg;
    cws_pkg::t_state  r_state;
    cws_pkg::t_state  n_state;
    cws_pkg::t_result r_res;
    cws_pkg::t_result n_res;
    logic             r_out_valid;
    logic             in_acc;

    assign o_s_tready  = ~r_out_valid | i_m_tready;
    assign in_acc      = i_s_tvalid & o_s_tready;
    assign o_cfg_ready = 1'b1;

    cws_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_action   (i_s_tdata[2:0]),
        .i_rotation (i_s_tdata[3]),
        .o_state    (n_state),
        .o_result   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_target <= 16'd100;
            r_cfg.spindle_cw  <= 1'b1;
            r_cfg.layer_steps <= 16'd1000;
            r_cfg.pitch_steps <= 10'd10;
        end else if (i_cfg_valid) begin
            unique case (cws_pkg::t_cfg_index'(i_cfg_index))
                cws_pkg::CFG_TURN_TARGET: r_cfg.turn_target <= i_cfg_data;
                cws_pkg::CFG_SPINDLE_CW:  r_cfg.spindle_cw  <= i_cfg_data[0];
                cws_pkg::CFG_LAYER_STEPS: r_cfg.layer_steps <= i_cfg_data;
                cws_pkg::CFG_PITCH_STEPS: r_cfg.pitch_steps <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= cws_pkg::PH_STOP;
            r_state.turns      <= 16'd0;
            r_state.trav_dir   <= 1'b1;
            r_state.rot_seen   <= 1'b0;
            r_state.sp_timer   <= 8'd0;
            r_state.tr_timer   <= 8'd0;
            r_state.layer_pos  <= 16'd0;
            r_state.pitch_mark <= 16'd0;
            r_state.manual     <= 1'b1;
            r_state.speed      <= 4'd1;
            r_state.motor_en   <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_res};

    // winding stopped: motor must be off in the same result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.finished |-> !r_res.motor_on)
        else $error("finished result with motor enabled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.speed >= cws_pkg::SPEED_MIN && r_state.speed <= cws_pkg::SPEED_MAX)
        else $error("speed level out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_res.finished |=> r_state.phase == cws_pkg::PH_STOP)
        else $error("target reached but sequencer not stopped");

    // a stalled result is never dropped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid && $stable(r_res))
        else $error("pending result lost under back-pressure");

endmodule
